// ===== src/rmf_pkg.sv =====
package rmf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int OUT_BITS    = 24;
    localparam int MAX_HALF    = 8;
    localparam int NPTS        = 2 * MAX_HALF + 1;
    localparam int IDX_W       = $clog2(NPTS + 1);
    localparam int WIN_DEPTH   = 32;
    localparam int WIN_AW      = $clog2(WIN_DEPTH);
    localparam int SLOPE_FRAC  = 16;
    localparam int VAL_W       = 41;
    localparam int MAG_W       = SAMPLE_BITS + SLOPE_FRAC;
    localparam int CNT_W       = $clog2(MAG_W + 1);
    localparam int DEN_W       = IDX_W;
    localparam int X_W         = IDX_W + 1;
    localparam int HALF_W      = 4;
    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(5);

    // Where a finished median goes.
    typedef enum logic [1:0] {
        DST_INNER,
        DST_BETA,
        DST_LEVEL
    } t_dst;

    typedef struct packed {
        logic                     win_we;
        logic [WIN_AW-1:0]        win_waddr;
        logic [WIN_AW-1:0]        win_ra;
        logic [WIN_AW-1:0]        win_rb;
        logic                     div_start;
        logic                     div_gt;
        logic [DEN_W-1:0]         div_den;
        logic                     sw_en;
        logic                     sw_lvl;
        logic [IDX_W-1:0]         sw_addr;
        logic [IDX_W-1:0]         buf_ra;
        logic [IDX_W-1:0]         buf_rb;
        logic                     med_src;
        logic                     cmp_en;
        logic                     cmp_last;
        logic [IDX_W-1:0]         k_lo;
        logic [IDX_W-1:0]         k_hi;
        logic                     fin_en;
        t_dst                     fin_dst;
        logic [IDX_W-1:0]         fin_addr;
        logic                     beta_clr;
        logic                     mul_en;
        logic signed [X_W-1:0]    mul_x;
        logic                     raw_cap;
        logic                     out_load;
        logic                     out_last;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== src/rmf_ram.sv =====
module rmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== src/rmf_div.sv =====
module rmf_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [rmf_pkg::MAG_W-1:0]          i_mag,
    input  logic [rmf_pkg::DEN_W-1:0]          i_den,
    input  logic                               i_neg,
    output logic                               o_done,
    output logic signed [rmf_pkg::VAL_W-1:0]   o_quot
);

    logic                            r_busy;
    logic                            r_done;
    logic [rmf_pkg::CNT_W-1:0]       r_cnt;
    logic [rmf_pkg::DEN_W-1:0]       r_rem;
    logic [rmf_pkg::MAG_W-1:0]       r_q;
    logic [rmf_pkg::DEN_W-1:0]       r_den;
    logic                            r_neg;
    logic [rmf_pkg::DEN_W:0]         trial;
    logic                            fits;
    logic [rmf_pkg::VAL_W-1:0]       qext;

    // One quotient bit per cycle; the dividend shifts out of r_q as the
    // quotient shifts in.
    assign trial = {r_rem, r_q[rmf_pkg::MAG_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rmf_pkg::CNT_W'(rmf_pkg::MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_mag;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_q   <= {r_q[rmf_pkg::MAG_W-2:0], fits};
            r_rem <= fits ? rmf_pkg::DEN_W'(trial - {1'b0, r_den})
                          : rmf_pkg::DEN_W'(trial);
        end
    end

    // A negative quotient is floored: a nonzero remainder pulls it down by one.
    assign qext   = rmf_pkg::VAL_W'(r_q);
    assign o_quot = r_neg ? -signed'(qext + rmf_pkg::VAL_W'(r_rem != '0)) : signed'(qext);
    assign o_done = r_done;

endmodule

// ===== src/rmf_dp.sv =====
module rmf_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rmf_pkg::t_cmd                         i_cmd,
    output rmf_pkg::t_sts                         o_sts,
    input  logic signed [rmf_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [rmf_pkg::SAMPLE_BITS-1:0] o_raw,
    output logic signed [rmf_pkg::OUT_BITS-1:0]   o_filtered,
    output logic                                  o_last
);

    localparam int VW = rmf_pkg::VAL_W;
    localparam logic signed [VW:0] SAT_HI = (VW + 1)'(2 ** (rmf_pkg::OUT_BITS - 1) - 1);
    localparam logic signed [VW:0] SAT_LO = -SAT_HI - (VW + 1)'(1);
    localparam logic signed [VW:0] HALF_LSB = (VW + 1)'(2 ** (rmf_pkg::SLOPE_FRAC
                                                     - rmf_pkg::FRAC_BITS - 1));

    logic [rmf_pkg::SAMPLE_BITS-1:0]  ya_bits, yb_bits;
    logic signed [rmf_pkg::SAMPLE_BITS-1:0] ya, yb;
    logic signed [rmf_pkg::SAMPLE_BITS:0]   diff;
    logic [rmf_pkg::SAMPLE_BITS:0]          dmag;
    logic [rmf_pkg::MAG_W-1:0]              num_mag;
    logic                                   div_done;
    logic signed [VW-1:0]                   slope;
    logic signed [VW-1:0]                   level;
    logic [VW-1:0]                          s_wdata;
    logic [VW-1:0]                          sa_bits, sb_bits, ia_bits, ib_bits;
    logic signed [VW-1:0]                   va, vb;
    logic                                   lt, le;
    logic [rmf_pkg::IDX_W-1:0]              tot_lt, tot_le;
    logic signed [VW:0]                     sum2;
    logic signed [VW-1:0]                   mean;
    logic signed [VW:0]                     rnd;
    logic signed [VW:0]                     shifted;
    logic signed [rmf_pkg::OUT_BITS-1:0]    sat;
    logic                                   i_we;

    logic signed [VW-1:0]                   r_beta;
    logic signed [VW-1:0]                   r_prod;
    logic signed [VW-1:0]                   r_lvl;
    logic signed [VW-1:0]                   r_lo, r_hi;
    logic [rmf_pkg::IDX_W-1:0]              r_lt, r_le;
    logic signed [rmf_pkg::SAMPLE_BITS-1:0] r_raw;
    logic                                   r_valid;

    rmf_ram #(
        .WIDTH (rmf_pkg::SAMPLE_BITS),
        .DEPTH (rmf_pkg::WIN_DEPTH)
    ) u_win (
        .i_clk     (i_clk),
        .i_we      (i_cmd.win_we),
        .i_waddr   (i_cmd.win_waddr),
        .i_wdata   (i_sample),
        .i_raddr_a (i_cmd.win_ra),
        .i_raddr_b (i_cmd.win_rb),
        .o_rdata_a (ya_bits),
        .o_rdata_b (yb_bits)
    );

    assign ya = signed'(ya_bits);
    assign yb = signed'(yb_bits);

    // Slope numerator oriented so that the x difference is positive.
    assign diff    = i_cmd.div_gt ? (ya - yb) : (yb - ya);
    assign dmag    = diff[rmf_pkg::SAMPLE_BITS] ? unsigned'(-diff) : unsigned'(diff);
    assign num_mag = {dmag[rmf_pkg::SAMPLE_BITS-1:0], {rmf_pkg::SLOPE_FRAC{1'b0}}};

    rmf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_mag   (num_mag),
        .i_den   (i_cmd.div_den),
        .i_neg   (diff[rmf_pkg::SAMPLE_BITS]),
        .o_done  (div_done),
        .o_quot  (slope)
    );

    assign level   = (VW'(ya) <<< rmf_pkg::SLOPE_FRAC) - r_prod;
    assign s_wdata = i_cmd.sw_lvl ? level : slope;

    rmf_ram #(
        .WIDTH (VW),
        .DEPTH (rmf_pkg::NPTS)
    ) u_sbuf (
        .i_clk     (i_clk),
        .i_we      (i_cmd.sw_en),
        .i_waddr   (i_cmd.sw_addr),
        .i_wdata   (s_wdata),
        .i_raddr_a (i_cmd.buf_ra),
        .i_raddr_b (i_cmd.buf_rb),
        .o_rdata_a (sa_bits),
        .o_rdata_b (sb_bits)
    );

    assign i_we = i_cmd.fin_en && (i_cmd.fin_dst == rmf_pkg::DST_INNER);

    rmf_ram #(
        .WIDTH (VW),
        .DEPTH (rmf_pkg::NPTS)
    ) u_ibuf (
        .i_clk     (i_clk),
        .i_we      (i_we),
        .i_waddr   (i_cmd.fin_addr),
        .i_wdata   (mean),
        .i_raddr_a (i_cmd.buf_ra),
        .i_raddr_b (i_cmd.buf_rb),
        .o_rdata_a (ia_bits),
        .o_rdata_b (ib_bits)
    );

    assign va = signed'(i_cmd.med_src ? ia_bits : sa_bits);
    assign vb = signed'(i_cmd.med_src ? ib_bits : sb_bits);

    // Rank selection: a candidate holds sorted position k when the count of
    // smaller values is at most k and the count of values not larger exceeds k.
    assign lt     = vb < va;
    assign le     = vb <= va;
    assign tot_lt = r_lt + rmf_pkg::IDX_W'(lt);
    assign tot_le = r_le + rmf_pkg::IDX_W'(le);

    assign sum2 = (VW + 1)'(r_lo) + (VW + 1)'(r_hi);
    assign mean = VW'(sum2 >>> 1);

    assign rnd     = (VW + 1)'(r_lvl) + HALF_LSB;
    assign shifted = rnd >>> (rmf_pkg::SLOPE_FRAC - rmf_pkg::FRAC_BITS);
    always_comb begin
        priority if (shifted > SAT_HI) begin
            sat = rmf_pkg::OUT_BITS'(SAT_HI);
        end else if (shifted < SAT_LO) begin
            sat = rmf_pkg::OUT_BITS'(SAT_LO);
        end else begin
            sat = rmf_pkg::OUT_BITS'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= '0;
            r_le <= '0;
        end else if (i_cmd.cmp_en) begin
            if (i_cmd.cmp_last) begin
                r_lt <= '0;
                r_le <= '0;
            end else begin
                r_lt <= tot_lt;
                r_le <= tot_le;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_en && i_cmd.cmp_last) begin
            if (tot_lt <= i_cmd.k_lo && i_cmd.k_lo < tot_le) begin
                r_lo <= va;
            end
            if (tot_lt <= i_cmd.k_hi && i_cmd.k_hi < tot_le) begin
                r_hi <= va;
            end
        end
        if (i_cmd.beta_clr) begin
            r_beta <= '0;
        end else if (i_cmd.fin_en && i_cmd.fin_dst == rmf_pkg::DST_BETA) begin
            r_beta <= mean;
        end
        if (i_cmd.fin_en && i_cmd.fin_dst == rmf_pkg::DST_LEVEL) begin
            r_lvl <= mean;
        end
        if (i_cmd.mul_en) begin
            r_prod <= VW'(r_beta * i_cmd.mul_x);
        end
        if (i_cmd.raw_cap) begin
            r_raw <= ya;
        end
    end

    // Output register: a result waits here while the next one is computed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_raw      <= r_raw;
            o_filtered <= sat;
            o_last     <= i_cmd.out_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_valid || i_ready;

endmodule

// ===== src/rmf_ctrl.sv =====
module rmf_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tlast,
    output logic                              o_s_tready,
    input  logic                              i_cfg_we,
    input  logic [rmf_pkg::HALF_W-1:0]        i_cfg_wdata,
    input  rmf_pkg::t_sts                     i_sts,
    output rmf_pkg::t_cmd                     o_cmd
);

    localparam int IW = rmf_pkg::IDX_W;
    localparam int AW = rmf_pkg::WIN_AW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SL_RD,
        ST_SL_DIV,
        ST_SL_WAIT,
        ST_MD_RD,
        ST_MD_CMP,
        ST_MD_FIN,
        ST_LV_RD,
        ST_LV_MUL,
        ST_LV_WR,
        ST_OUT
    } t_state;

    t_state                    r_state;
    logic [AW-1:0]             r_wptr;
    logic [AW-1:0]             r_base;
    logic [IW-1:0]             r_bp, r_pend, r_l, r_m;
    logic [IW-1:0]             r_i, r_j, r_c, r_p, r_a, r_b, r_n;
    logic [rmf_pkg::HALF_W-1:0] r_half;
    logic                      r_flush, r_last, r_src;
    rmf_pkg::t_dst             r_dst;

    logic                      accept;
    logic [IW-1:0]             h;
    logic [IW-1:0]             bp1, pend1;
    logic                      want;
    logic [IW-1:0]             span, l_new, r_new, m_new;
    logic [IW-1:0]             n_j;
    logic                      lv_phase;
    logic [IW-1:0]             ra_idx;

    assign accept     = i_s_tvalid && (r_state == ST_IDLE);
    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        priority if (r_half == '0) begin
            h = IW'(1);
        end else if (IW'(r_half) > IW'(rmf_pkg::MAX_HALF)) begin
            h = IW'(rmf_pkg::MAX_HALF);
        end else begin
            h = IW'(r_half);
        end
    end

    always_comb begin
        bp1   = (r_bp < IW'(rmf_pkg::NPTS)) ? r_bp + 1'b1 : r_bp;
        pend1 = (r_pend < IW'(rmf_pkg::NPTS)) ? r_pend + 1'b1 : r_pend;
        if (pend1 > bp1) begin
            pend1 = bp1;
        end
    end

    // Window of the answered point: l points to its left (the older side), r to its
    // right, clipped by the batch and by h.
    assign want  = r_flush ? (r_pend != '0) : (r_pend > h);
    assign span  = r_bp - r_pend;
    assign l_new = (span < h) ? span : h;
    assign r_new = ((r_pend - 1'b1) < h) ? (r_pend - 1'b1) : h;
    assign m_new = l_new + r_new + 1'b1;
    assign n_j   = ((r_j + 1'b1) == r_i) ? r_j + IW'(2) : r_j + 1'b1;

    assign lv_phase = (r_state == ST_LV_RD) || (r_state == ST_LV_MUL) ||
                      (r_state == ST_LV_WR);
    assign ra_idx   = lv_phase ? r_p : r_i;

    always_comb begin
        o_cmd           = '0;
        o_cmd.win_we    = accept;
        o_cmd.win_waddr = r_wptr;
        o_cmd.win_ra    = r_base + AW'(ra_idx);
        o_cmd.win_rb    = r_base + AW'(r_j);
        o_cmd.div_start = (r_state == ST_SL_DIV);
        o_cmd.div_gt    = r_i > r_j;
        o_cmd.div_den   = (r_i > r_j) ? r_i - r_j : r_j - r_i;
        o_cmd.sw_en     = (r_state == ST_SL_WAIT && i_sts.div_done) ||
                          (r_state == ST_LV_WR);
        o_cmd.sw_lvl    = (r_state == ST_LV_WR);
        o_cmd.sw_addr   = (r_state == ST_LV_WR) ? r_p : r_c;
        o_cmd.buf_ra    = r_a;
        o_cmd.buf_rb    = r_b;
        o_cmd.med_src   = r_src;
        o_cmd.cmp_en    = (r_state == ST_MD_CMP);
        o_cmd.cmp_last  = (r_b == r_n - 1'b1);
        o_cmd.k_lo      = (r_n - 1'b1) >> 1;
        o_cmd.k_hi      = r_n >> 1;
        o_cmd.fin_en    = (r_state == ST_MD_FIN);
        o_cmd.fin_dst   = r_dst;
        o_cmd.fin_addr  = r_i;
        o_cmd.beta_clr  = (r_state == ST_DECIDE) && want && (m_new == IW'(1));
        o_cmd.mul_en    = (r_state == ST_LV_MUL);
        o_cmd.mul_x     = signed'({1'b0, r_p}) - signed'({1'b0, r_l});
        o_cmd.raw_cap   = (r_state == ST_LV_WR) && (r_p == r_l);
        o_cmd.out_load  = (r_state == ST_OUT) && i_sts.out_free;
        o_cmd.out_last  = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wptr  <= '0;
            r_bp    <= '0;
            r_pend  <= '0;
            r_half  <= rmf_pkg::HALF_RESET;
            r_flush <= 1'b0;
            r_last  <= 1'b0;
            r_src   <= 1'b0;
            r_dst   <= rmf_pkg::DST_INNER;
            r_base  <= '0;
            r_l     <= '0;
            r_m     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_c     <= '0;
            r_p     <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_n     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_half <= i_cfg_wdata;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_wptr  <= r_wptr + 1'b1;
                        r_bp    <= bp1;
                        r_pend  <= pend1;
                        r_flush <= i_s_tlast;
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (want) begin
                        r_pend <= r_pend - 1'b1;
                        r_l    <= l_new;
                        r_m    <= m_new;
                        r_base <= r_wptr - AW'(r_pend) - AW'(l_new);
                        r_last <= r_flush && (r_pend == IW'(1));
                        if (m_new > IW'(1)) begin
                            r_i     <= '0;
                            r_j     <= IW'(1);
                            r_c     <= '0;
                            r_state <= ST_SL_RD;
                        end else begin
                            r_p     <= '0;
                            r_state <= ST_LV_RD;
                        end
                    end else begin
                        if (r_flush) begin
                            r_bp <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_SL_RD: begin
                    r_state <= ST_SL_DIV;
                end
                ST_SL_DIV: begin
                    r_state <= ST_SL_WAIT;
                end
                ST_SL_WAIT: begin
                    if (i_sts.div_done) begin
                        r_c <= r_c + 1'b1;
                        if (n_j >= r_m) begin
                            r_a     <= '0;
                            r_b     <= '0;
                            r_n     <= r_m - 1'b1;
                            r_src   <= 1'b0;
                            r_dst   <= rmf_pkg::DST_INNER;
                            r_state <= ST_MD_RD;
                        end else begin
                            r_j     <= n_j;
                            r_state <= ST_SL_RD;
                        end
                    end
                end
                ST_MD_RD: begin
                    r_state <= ST_MD_CMP;
                end
                ST_MD_CMP: begin
                    if (r_b == r_n - 1'b1) begin
                        r_b <= '0;
                        if (r_a == r_n - 1'b1) begin
                            r_state <= ST_MD_FIN;
                        end else begin
                            r_a     <= r_a + 1'b1;
                            r_state <= ST_MD_RD;
                        end
                    end else begin
                        r_b     <= r_b + 1'b1;
                        r_state <= ST_MD_RD;
                    end
                end
                ST_MD_FIN: begin
                    unique case (r_dst)
                        rmf_pkg::DST_INNER: begin
                            if (r_i == r_m - 1'b1) begin
                                r_a     <= '0;
                                r_b     <= '0;
                                r_n     <= r_m;
                                r_src   <= 1'b1;
                                r_dst   <= rmf_pkg::DST_BETA;
                                r_state <= ST_MD_RD;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_j     <= '0;
                                r_c     <= '0;
                                r_state <= ST_SL_RD;
                            end
                        end
                        rmf_pkg::DST_BETA: begin
                            r_p     <= '0;
                            r_state <= ST_LV_RD;
                        end
                        rmf_pkg::DST_LEVEL: begin
                            r_state <= ST_OUT;
                        end
                        default: begin
                            r_state <= ST_OUT;
                        end
                    endcase
                end
                ST_LV_RD: begin
                    r_state <= ST_LV_MUL;
                end
                ST_LV_MUL: begin
                    r_state <= ST_LV_WR;
                end
                ST_LV_WR: begin
                    if (r_p == r_m - 1'b1) begin
                        r_a     <= '0;
                        r_b     <= '0;
                        r_n     <= r_m;
                        r_src   <= 1'b0;
                        r_dst   <= rmf_pkg::DST_LEVEL;
                        r_state <= ST_MD_RD;
                    end else begin
                        r_p     <= r_p + 1'b1;
                        r_state <= ST_LV_RD;
                    end
                end
                ST_OUT: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_DECIDE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/repeated_median_filter.sv =====
// Channel   Direction  Payload
// s_*       in         tdata = sample[15:0]; tlast = batch_end
// m_*       out        tdata = raw_sample[15:0], filtered[39:16]; tlast = last
// cfg_*     in         wdata = window half width [3:0], written whenever i_cfg_we is high
//
// A result's window holds m points, up to 17. Its time is set by the bit-serial slope
// divider and by the rank-select medians, which take a read state and then a compare
// state for each pair of values.
// An input is taken only when no result is being computed; results then wait
// in an output register, so a stalled output holds back only the next result.
// Reset is synchronous and active low and needs no clearing pass.
module repeated_median_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,    // [15:0] sample
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,    // [15:0] raw_sample, [39:16] filtered
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata
);

    rmf_pkg::t_cmd                            cmd;
    rmf_pkg::t_sts                            sts;
    logic signed [rmf_pkg::SAMPLE_BITS-1:0]   raw;
    logic signed [rmf_pkg::OUT_BITS-1:0]      filtered;

    rmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tlast   (i_s_tlast),
        .o_s_tready  (o_s_tready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rmf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_sample   (signed'(i_s_tdata)),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_raw      (raw),
        .o_filtered (filtered),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {filtered, raw};

endmodule

// ===== src/rmf_checker.sv =====
module rmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [15:0] i_s_tdata,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        i_cfg_we,
    input logic [3:0]  i_cfg_wdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output transfer dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output payload changed while stalled");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // No two input transfers come on consecutive cycles.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken on consecutive cycles");

endmodule

bind repeated_median_filter rmf_checker u_rmf_checker (.*);
